// ----- design/sp_pkg.sv -----
// ----------------------------------------------------------------------------
// sp_pkg
// Shared constants, register indexes and the CORDIC arctangent table for the
// sphere projection block.
// ----------------------------------------------------------------------------
package sp_pkg;

    // Default angle resolution in bits of a turn.
    localparam int SP_ANGLE_BITS = 16;

    // Field and register widths.
    localparam int COORD_W  = 16;
    localparam int SPAN_W   = 16;
    localparam int RADIUS_W = 15;
    localparam int CFG_W    = 16;
    localparam int IDX_W    = 2;

    // Register indexes of the configuration port.
    localparam logic [IDX_W-1:0] REG_WIDTH_SPAN  = 2'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT_SPAN = 2'd1;
    localparam logic [IDX_W-1:0] REG_RADIUS_X    = 2'd2;
    localparam logic [IDX_W-1:0] REG_RADIUS_Y    = 2'd3;

    // Register reset values.
    localparam logic [SPAN_W-1:0]   SPAN_RESET   = 16'd256;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 15'd128;

    // CORDIC datapath: Q2.30 with headroom, angle in 2^-32 turn plus sign.
    localparam int CORDIC_STEPS = 24;
    localparam int XY_W         = 34;
    localparam int Z_W          = 33;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [15:0]     Q15_MAX     = 16'sd32767;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [31:0] sp_atan(input logic [4:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'd536870912;
            5'd1:    val = 32'd316933406;
            5'd2:    val = 32'd167458908;
            5'd3:    val = 32'd85004756;
            5'd4:    val = 32'd42667330;
            5'd5:    val = 32'd21354465;
            5'd6:    val = 32'd10679838;
            5'd7:    val = 32'd5340245;
            5'd8:    val = 32'd2670163;
            5'd9:    val = 32'd1335087;
            5'd10:   val = 32'd667544;
            5'd11:   val = 32'd333772;
            5'd12:   val = 32'd166886;
            5'd13:   val = 32'd83443;
            5'd14:   val = 32'd41722;
            5'd15:   val = 32'd20861;
            5'd16:   val = 32'd10430;
            5'd17:   val = 32'd5215;
            5'd18:   val = 32'd2608;
            5'd19:   val = 32'd1304;
            5'd20:   val = 32'd652;
            5'd21:   val = 32'd326;
            5'd22:   val = 32'd163;
            5'd23:   val = 32'd81;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage

// ----- design/sp_channels.sv -----
// ----------------------------------------------------------------------------
// sp_channels
// Valid/ready stream interfaces for grid points in and projected points out.
// ----------------------------------------------------------------------------
interface sp_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] grid_x;
    logic signed [15:0] grid_y;

    modport source (output valid, output grid_x, output grid_y, input ready);
    modport sink   (input valid, input grid_x, input grid_y, output ready);
endinterface

interface sp_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] proj_x;
    logic signed [15:0] proj_y;

    modport source (output valid, output proj_x, output proj_y, input ready);
    modport sink   (input valid, input proj_x, input proj_y, output ready);
endinterface

// ----- design/sp_angle.sv -----
// ----------------------------------------------------------------------------
// sp_angle
// Pipelined restoring divider that turns a grid coordinate into an angle:
// floor(coord * 2^SCALE / span) - 2^OFFSET_SHIFT, modulo 2^ANGLE_BITS.
// ----------------------------------------------------------------------------
module sp_angle #(
    parameter int ANGLE_BITS   = sp_pkg::SP_ANGLE_BITS,
    parameter int SCALE        = sp_pkg::SP_ANGLE_BITS,
    parameter int OFFSET_SHIFT = sp_pkg::SP_ANGLE_BITS - 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic signed [sp_pkg::COORD_W-1:0] coord,
    input  logic [sp_pkg::SPAN_W-1:0]    span,
    output logic                         out_valid,
    output logic [ANGLE_BITS-1:0]        angle
);

    localparam int NB = sp_pkg::COORD_W + ANGLE_BITS;
    localparam int SW = sp_pkg::SPAN_W;

    // Per-stage registers; stage 0 is the capture stage.
    logic [NB-1:0]         num_reg [0:NB];
    logic [SW-1:0]         rem_reg [0:NB];
    logic [ANGLE_BITS-1:0] q_reg   [0:NB];
    logic [SW-1:0]         d_reg   [0:NB];
    logic                  neg_reg [0:NB];
    logic                  vld_reg [0:NB];

    logic [sp_pkg::COORD_W-1:0] mag;
    logic [ANGLE_BITS-1:0]      qf;
    logic                       fin_vld_reg;
    logic [ANGLE_BITS-1:0]      angle_reg;

    // Magnitude of the coordinate; the most negative value maps correctly.
    assign mag = coord[sp_pkg::COORD_W-1] ? (~coord + 1'b1) : coord;

    // Capture stage: magnitude scaled, sign kept, zero span read as one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg[0] <= NB'(mag) << SCALE;
            rem_reg[0] <= '0;
            q_reg[0]   <= '0;
            d_reg[0]   <= (span == '0) ? SW'(1) : span;
            neg_reg[0] <= coord[sp_pkg::COORD_W-1];
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar k = 0; k < NB; k++)
    begin : g_step
        logic [SW:0]   trial;
        logic          ge;
        logic [SW:0]   diff;

        assign trial = {rem_reg[k], num_reg[k][NB-1-k]};
        assign ge    = trial >= {1'b0, d_reg[k]};
        assign diff  = trial - {1'b0, d_reg[k]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[k+1] <= num_reg[k];
                rem_reg[k+1] <= ge ? diff[SW-1:0] : trial[SW-1:0];
                q_reg[k+1]   <= {q_reg[k][ANGLE_BITS-2:0], ge};
                d_reg[k+1]   <= d_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    // Floor correction for negative dividends, then the angle offset.
    always_comb
    begin
        if (!neg_reg[NB])
        begin
            qf = q_reg[NB];
        end
        else if (rem_reg[NB] != '0)
        begin
            qf = ~q_reg[NB];
        end
        else
        begin
            qf = ~q_reg[NB] + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            fin_vld_reg <= vld_reg[NB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= qf - (ANGLE_BITS'(1) << OFFSET_SHIFT);
        end
    end

    assign out_valid = fin_vld_reg;
    assign angle     = angle_reg;

endmodule

// ----- design/sp_cordic.sv -----
// ----------------------------------------------------------------------------
// sp_cordic
// Pipelined CORDIC, one rotation per stage, giving sine and cosine in Q1.15.
// ----------------------------------------------------------------------------
module sp_cordic #(
    parameter int ANGLE_BITS = sp_pkg::SP_ANGLE_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [ANGLE_BITS-1:0] angle,
    output logic                  out_valid,
    output logic signed [15:0]    sin_out,
    output logic signed [15:0]    cos_out
);

    localparam int N  = sp_pkg::CORDIC_STEPS;
    localparam int XW = sp_pkg::XY_W;
    localparam int ZW = sp_pkg::Z_W;

    logic signed [XW-1:0] x_reg    [0:N];
    logic signed [XW-1:0] y_reg    [0:N];
    logic signed [ZW-1:0] z_reg    [0:N];
    logic                 flip_reg [0:N];
    logic                 vld_reg  [0:N];

    logic signed [ZW-1:0] z_in;
    logic signed [ZW-1:0] z_fold;
    logic                 flip_in;
    logic signed [XW-1:0] x_fin;
    logic signed [XW-1:0] y_fin;
    logic signed [15:0]   s_q15;
    logic signed [15:0]   c_q15;
    logic                 out_vld_reg;
    logic signed [15:0]   sin_reg;
    logic signed [15:0]   cos_reg;

    // Round half away from zero to Q1.15 and saturate.
    function automatic logic signed [15:0] to_q15(input logic signed [XW-1:0] v);
        logic [XW-1:0] mag;
        logic [XW-1:0] r;
        logic [15:0]   res;
        mag = v[XW-1] ? (~v + 1'b1) : v;
        r   = (mag + (XW'(1) << 14)) >> 15;
        if (r > XW'(sp_pkg::Q15_MAX))
        begin
            res = sp_pkg::Q15_MAX;
        end
        else
        begin
            res = r[15:0];
        end
        return v[XW-1] ? $signed(~res + 1'b1) : $signed(res);
    endfunction

    // Widen to 32 bits of a turn and fold into the right half-plane.
    assign z_in = ZW'($signed({angle, {(32-ANGLE_BITS){1'b0}}}));

    always_comb
    begin
        if (z_in > (ZW'(1) <<< 30))
        begin
            z_fold  = z_in - (ZW'(1) <<< 31);
            flip_in = 1'b1;
        end
        else if (z_in < -(ZW'(1) <<< 30))
        begin
            z_fold  = z_in + (ZW'(1) <<< 31);
            flip_in = 1'b1;
        end
        else
        begin
            z_fold  = z_in;
            flip_in = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= sp_pkg::CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= z_fold;
            flip_reg[0] <= flip_in;
        end
    end

    // Rotation stages; arithmetic shifts round toward minus infinity.
    for (genvar k = 0; k < N; k++)
    begin : g_rot
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic signed [ZW-1:0] at;

        assign dx = y_reg[k] >>> k;
        assign dy = x_reg[k] >>> k;
        assign at = $signed({1'b0, sp_pkg::sp_atan(5'(k))});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[k][ZW-1])
                begin
                    x_reg[k+1] <= x_reg[k] - dx;
                    y_reg[k+1] <= y_reg[k] + dy;
                    z_reg[k+1] <= z_reg[k] - at;
                end
                else
                begin
                    x_reg[k+1] <= x_reg[k] + dx;
                    y_reg[k+1] <= y_reg[k] - dy;
                    z_reg[k+1] <= z_reg[k] + at;
                end
                flip_reg[k+1] <= flip_reg[k];
            end
        end
    end

    // Undo the fold and round both results.
    assign x_fin = flip_reg[N] ? -x_reg[N] : x_reg[N];
    assign y_fin = flip_reg[N] ? -y_reg[N] : y_reg[N];
    assign s_q15 = to_q15(y_fin);
    assign c_q15 = to_q15(x_fin);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= vld_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= s_q15;
            cos_reg <= c_q15;
        end
    end

    assign out_valid = out_vld_reg;
    assign sin_out   = sin_reg;
    assign cos_out   = cos_reg;

endmodule

// ----- design/sp_product.sv -----
// ----------------------------------------------------------------------------
// sp_product
// Scales the trigonometric values by the radii, truncating toward zero.
// The last stage is the output register of the block.
// ----------------------------------------------------------------------------
module sp_product (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [15:0]            cos_lat,
    input  logic signed [15:0]            sin_lon,
    input  logic signed [15:0]            sin_lat,
    input  logic [sp_pkg::RADIUS_W-1:0]   radius_x,
    input  logic [sp_pkg::RADIUS_W-1:0]   radius_y,
    output logic                          out_valid,
    output logic signed [15:0]            proj_x,
    output logic signed [15:0]            proj_y
);

    logic                vld1_reg;
    logic                vld2_reg;
    logic                vld3_reg;
    logic signed [31:0]  cs_reg;
    logic signed [31:0]  sy_reg;
    logic signed [47:0]  p_reg;
    logic signed [31:0]  sy2_reg;
    logic signed [47:0]  p_adj;
    logic signed [31:0]  sy_adj;
    logic signed [47:0]  px_full;
    logic signed [31:0]  py_full;
    logic signed [15:0]  px_reg;
    logic signed [15:0]  py_reg;

    // Valid bits follow the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    // Bias negative products so the arithmetic shift truncates toward zero.
    assign p_adj   = p_reg[47] ? (p_reg + 48'sd1073741823) : p_reg;
    assign sy_adj  = sy2_reg[31] ? (sy2_reg + 32'sd32767) : sy2_reg;
    assign px_full = p_adj >>> 30;
    assign py_full = sy_adj >>> 15;

    // First multiply, second multiply, then the scaled result.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cs_reg  <= cos_lat * sin_lon;
            sy_reg  <= sin_lat * $signed({1'b0, radius_y});
            p_reg   <= cs_reg * $signed({1'b0, radius_x});
            sy2_reg <= sy_reg;
            px_reg  <= px_full[15:0];
            py_reg  <= py_full[15:0];
        end
    end

    assign out_valid = vld3_reg;
    assign proj_x    = px_reg;
    assign proj_y    = py_reg;

endmodule

// ----- design/sphere_projection.sv -----
// ----------------------------------------------------------------------------
// sphere_projection
// Projects a grid point onto a sphere seen from the front, in fixed point.
//
//   Channel    Dir   Word contents
//   grid_in    in    grid_x, grid_y (signed 16 bit)
//   proj_out   out   proj_x, proj_y (signed 16 bit)
//   cfg_*      in    plain register writes (width/height span, radii)
//
// One word is taken per cycle while the output is not stalled; the pipeline is made of
// the one-bit-per-stage dividers and the 24 CORDIC stages.
// The whole pipeline advances whenever the output register is empty or taken,
// so a stall on the output holds every stage and loses nothing.
// Reset clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module sphere_projection #(
    parameter int ANGLE_BITS = sp_pkg::SP_ANGLE_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    sp_in_if.sink                       grid_in,
    sp_out_if.source                    proj_out,
    input  logic                        cfg_we,
    input  logic [sp_pkg::IDX_W-1:0]    cfg_index,
    input  logic [sp_pkg::CFG_W-1:0]    cfg_data
);

    logic [sp_pkg::SPAN_W-1:0]   width_span_reg;
    logic [sp_pkg::SPAN_W-1:0]   height_span_reg;
    logic [sp_pkg::RADIUS_W-1:0] radius_x_reg;
    logic [sp_pkg::RADIUS_W-1:0] radius_y_reg;

    logic                  adv;
    logic                  lon_vld;
    logic                  lat_vld;
    logic [ANGLE_BITS-1:0] lon_angle;
    logic [ANGLE_BITS-1:0] lat_angle;
    logic                  trig_vld;
    logic signed [15:0]    sin_lat;
    logic signed [15:0]    cos_lat;
    logic signed [15:0]    sin_lon;
    logic                  out_vld;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_span_reg  <= sp_pkg::SPAN_RESET;
            height_span_reg <= sp_pkg::SPAN_RESET;
            radius_x_reg    <= sp_pkg::RADIUS_RESET;
            radius_y_reg    <= sp_pkg::RADIUS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sp_pkg::REG_WIDTH_SPAN:  width_span_reg  <= cfg_data;
                sp_pkg::REG_HEIGHT_SPAN: height_span_reg <= cfg_data;
                sp_pkg::REG_RADIUS_X:    radius_x_reg    <= cfg_data[sp_pkg::RADIUS_W-1:0];
                sp_pkg::REG_RADIUS_Y:    radius_y_reg    <= cfg_data[sp_pkg::RADIUS_W-1:0];
                default:                 ;
            endcase
        end
    end

    // The pipeline moves when the output register is free.
    assign adv           = !out_vld || proj_out.ready;
    assign grid_in.ready = adv;

    // Longitude: a full turn over width_span, offset by half a turn.
    sp_angle #(
        .ANGLE_BITS   (ANGLE_BITS),
        .SCALE        (ANGLE_BITS),
        .OFFSET_SHIFT (ANGLE_BITS - 1)
    ) u_lon (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (grid_in.valid),
        .coord     (grid_in.grid_x),
        .span      (width_span_reg),
        .out_valid (lon_vld),
        .angle     (lon_angle)
    );

    // Latitude: half a turn over height_span, offset by a quarter turn.
    sp_angle #(
        .ANGLE_BITS   (ANGLE_BITS),
        .SCALE        (ANGLE_BITS - 1),
        .OFFSET_SHIFT (ANGLE_BITS - 2)
    ) u_lat (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (grid_in.valid),
        .coord     (grid_in.grid_y),
        .span      (height_span_reg),
        .out_valid (lat_vld),
        .angle     (lat_angle)
    );

    sp_cordic #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_cordic_lat (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (lat_vld),
        .angle     (lat_angle),
        .out_valid (trig_vld),
        .sin_out   (sin_lat),
        .cos_out   (cos_lat)
    );

    sp_cordic #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_cordic_lon (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (lon_vld),
        .angle     (lon_angle),
        .out_valid (),
        .sin_out   (sin_lon),
        .cos_out   ()
    );

    sp_product u_product (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (trig_vld),
        .cos_lat   (cos_lat),
        .sin_lon   (sin_lon),
        .sin_lat   (sin_lat),
        .radius_x  (radius_x_reg),
        .radius_y  (radius_y_reg),
        .out_valid (out_vld),
        .proj_x    (proj_out.proj_x),
        .proj_y    (proj_out.proj_y)
    );

    assign proj_out.valid = out_vld;

endmodule

// ----- tb/sv/sphere_projection_tb.sv -----
// ----------------------------------------------------------------------------
// sphere_projection_tb
// Self-checking bench for the sphere projection block. Grid points are sent
// through the input channel with random gaps, projected points are taken with
// random stalls, and every word is compared with a fixed-point prediction
// kept in the bench. Spans and radii are changed between phases.
// ----------------------------------------------------------------------------
module sphere_projection_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ABITS     = sp_pkg::SP_ANGLE_BITS;
    localparam int LATENCY   = 47 + ABITS;
    localparam int MAX_CYCLE = 2000000;

    typedef struct packed {
        logic signed [15:0] px;
        logic signed [15:0] py;
    } point_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [sp_pkg::IDX_W-1:0] cfg_index;
    logic [sp_pkg::CFG_W-1:0] cfg_data;

    sp_in_if  grid_ch();
    sp_out_if proj_ch();

    sphere_projection #(.ANGLE_BITS(ABITS)) DUT (
        .clk(clk), .rst_n(rst_n), .grid_in(grid_ch.sink), .proj_out(proj_ch.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Bench copy of the registers.
    logic [15:0] span_w, span_h;
    logic [14:0] rad_x, rad_y;

    point_t expected_points[$];
    int     errors;
    int     cycles;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLE)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic longint floor_shift(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -((-v - 1) >>> s) - 1;
    endfunction

    function automatic longint round_q15(longint v);
        longint r;
        if (v >= 0)
            r = (v + (64'sd1 << 14)) >>> 15;
        else
            r = -((-v + (64'sd1 << 14)) >>> 15);
        if (r > 32767)
            r = 32767;
        if (r < -32767)
            r = -32767;
        return r;
    endfunction

    function automatic longint atan_step(int i);
        case (i)
            0: return 536870912;   1: return 316933406;  2: return 167458908;
            3: return 85004756;    4: return 42667330;   5: return 21354465;
            6: return 10679838;    7: return 5340245;    8: return 2670163;
            9: return 1335087;     10: return 667544;    11: return 333772;
            12: return 166886;     13: return 83443;     14: return 41722;
            15: return 20861;      16: return 10430;     17: return 5215;
            18: return 2608;       19: return 1304;      20: return 652;
            21: return 326;        22: return 163;       default: return 81;
        endcase
    endfunction

    // Rotation by a fraction of a turn; sine and cosine in Q1.15.
    task automatic turn_sin_cos(input longint angle, output longint s, output longint c);
        longint u, z, x, y, dx, dy;
        bit flip;
        u = (angle & ((64'sd1 << ABITS) - 1)) << (32 - ABITS);
        z = (u >= 64'sh80000000) ? u - 64'sh100000000 : u;
        flip = 0;
        x = 652032874;
        y = 0;
        if (z > (64'sd1 << 30))
        begin
            z -= (64'sd1 << 31);
            flip = 1;
        end
        else if (z < -(64'sd1 << 30))
        begin
            z += (64'sd1 << 31);
            flip = 1;
        end
        for (int i = 0; i < 24; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atan_step(i);
            end
            else
            begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        if (flip)
        begin
            x = -x; y = -y;
        end
        s = round_q15(y);
        c = round_q15(x);
    endtask

    function automatic longint div_floor(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q -= 1;
        return q;
    endfunction

    // Projected point for one grid point under the current registers.
    task automatic project_point(input logic signed [15:0] gx, input logic signed [15:0] gy,
                                 output point_t p);
        longint w, h, lon, lat, sl, cl, so, co, px, py;
        w = (span_w == 0) ? 1 : span_w;
        h = (span_h == 0) ? 1 : span_h;
        lon = div_floor(longint'(gx) * (64'sd1 << ABITS), w) - (64'sd1 << (ABITS - 1));
        lat = div_floor(longint'(gy) * (64'sd1 << (ABITS - 1)), h) - (64'sd1 << (ABITS - 2));
        turn_sin_cos(lat, sl, cl);
        turn_sin_cos(lon, so, co);
        px = (cl * so * longint'(rad_x)) / (64'sd1 << 30);
        py = (sl * longint'(rad_y)) / (64'sd1 << 15);
        p.px = px[15:0];
        p.py = py[15:0];
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    // Result checker with random output stalls.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (proj_ch.valid && proj_ch.ready)
            begin
                if (expected_points.size() == 0)
                    report_mismatch("unexpected word", 1, 0);
                else
                begin
                    point_t e;
                    e = expected_points.pop_front();
                    if (proj_ch.proj_x !== e.px)
                        report_mismatch("proj_x", proj_ch.proj_x, e.px);
                    if (proj_ch.proj_y !== e.py)
                        report_mismatch("proj_y", proj_ch.proj_y, e.py);
                end
            end
            if ((cycles / 512) % 4 == 0)
                proj_ch.ready <= 1'b1;
            else if ($urandom_range(0, 99) < 3)
                proj_ch.ready <= 1'b0;
            else
                proj_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Drops valid only when a gap follows, so the next word may follow at once.
    task automatic idle_gap();
        int n;
        n = 0;
        if ((cycles / 700) % 3 != 0)
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        if (n > 0)
        begin
            grid_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Sends one grid point and queues its projection.
    task automatic send_point(input logic [15:0] gx, input logic [15:0] gy);
        point_t p;
        grid_ch.valid  <= 1'b1;
        grid_ch.grid_x <= gx;
        grid_ch.grid_y <= gy;
        project_point(gx, gy, p);
        expected_points.push_back(p);
        do
            @(posedge clk);
        while (!grid_ch.ready);
        idle_gap();
    endtask

    task automatic drain();
        grid_ch.valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [sp_pkg::IDX_W-1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            sp_pkg::REG_WIDTH_SPAN:  span_w = val;
            sp_pkg::REG_HEIGHT_SPAN: span_h = val;
            sp_pkg::REG_RADIUS_X:    rad_x = val[14:0];
            default:                 rad_y = val[14:0];
        endcase
    endtask

    task automatic set_regs(input logic [15:0] w, input logic [15:0] h,
                            input logic [15:0] rx, input logic [15:0] ry);
        drain();
        write_reg(sp_pkg::REG_WIDTH_SPAN, w);
        write_reg(sp_pkg::REG_HEIGHT_SPAN, h);
        write_reg(sp_pkg::REG_RADIUS_X, rx);
        write_reg(sp_pkg::REG_RADIUS_Y, ry);
        cfg_we <= 1'b0;
    endtask

    // Field extremes, the quarter points of a turn and wrap outside one period.
    task automatic test_directed();
        logic [15:0] vals[8] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF,
                                 16'd64, 16'd128, 16'd192, 16'd256};
        foreach (vals[i])
            send_point(vals[i], vals[(i + 3) % 8]);
        send_point(16'd512, 16'd384);
        send_point(16'hFF00, 16'hFE80);
        send_point(16'h5555, 16'hAAAA);
        send_point(16'd32, 16'd224);
    endtask

    // Zero spans behave as one, zero radii give zero.
    task automatic test_zero_cases();
        set_regs(16'd0, 16'd0, 16'd1000, 16'd1000);
        repeat (6) send_point(16'($urandom), 16'($urandom));
        send_point(16'd0, 16'd0);
        set_regs(16'd300, 16'd200, 16'd0, 16'd0);
        repeat (6) send_point(16'($urandom), 16'($urandom));
    endtask

    task automatic random_block(input int n, input logic [15:0] w, input logic [15:0] h);
        logic [15:0] gx, gy;
        repeat (n)
        begin
            // Mostly points inside one period, some anywhere.
            if ($urandom_range(0, 3) != 0)
            begin
                gx = 16'($urandom_range(0, w));
                gy = 16'($urandom_range(0, h));
            end
            else
            begin
                gx = 16'($urandom);
                gy = 16'($urandom);
            end
            send_point(gx, gy);
        end
    endtask

    // Several register settings, extremes among them.
    task automatic test_random_settings();
        set_regs(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF);
        random_block(250, 16'hFFFF, 16'hFFFF);
        set_regs(16'd1, 16'd1, 16'h7FFF, 16'd1);
        random_block(150, 16'd1, 16'd1);
        for (int k = 0; k < 8; k++)
        begin
            logic [15:0] w, h;
            w = 16'($urandom_range(1, 2000));
            h = 16'($urandom_range(1, 2000));
            if (k == 3)
                w = 16'($urandom);
            set_regs(w, h, 16'($urandom_range(0, 32767)), 16'($urandom_range(0, 32767)));
            random_block(160, w, h);
        end
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        grid_ch.valid = 1'b0;
        grid_ch.grid_x = '0;
        grid_ch.grid_y = '0;
        proj_ch.ready = 1'b0;
        span_w = sp_pkg::SPAN_RESET;
        span_h = sp_pkg::SPAN_RESET;
        rad_x = sp_pkg::RADIUS_RESET;
        rad_y = sp_pkg::RADIUS_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_zero_cases();
        test_random_settings();
        drain();

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
